// ===== rtl/core/ffba_pkg.sv =====
// Shared types and constants for the first-fit block allocator.
`timescale 1ns / 1ps

package ffba_pkg;

	localparam int MAX_BLOCKS = 64;
	localparam int IDX_W = $clog2(MAX_BLOCKS);
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int ADDR_W = 32;
	localparam int SIZE_W = 24;
	localparam int CFG_IDX_W = 2;
	localparam logic [ADDR_W-1:0] HEADER_BYTES = 32'd24;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HEAP_START = 2'd0,
		CFG_HEAP_LIMIT = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OOM       = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [SIZE_W-1:0] size;
		logic              free;
	} entry_t;

	typedef struct packed {
		logic load_req;
		logic scan_en;
		logic commit;
		logic found;
	} ctrl_cmd_t;

	typedef struct packed {
		logic hit;
		logic miss;
		logic out_free;
	} dp_status_t;

endpackage

// ===== rtl/core/ffba_ctrl.sv =====
// Request sequencer: accept, table scan, commit.
`timescale 1ns / 1ps

module ffba_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  ffba_pkg::dp_status_t  dp_status,
	output ffba_pkg::ctrl_cmd_t   cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_COMMIT
	} state_t;

	state_t state_q;
	logic   found_q;

	assign in_stall     = (state_q != S_IDLE);
	assign cmd.load_req = (state_q == S_IDLE) && in_valid;
	assign cmd.scan_en  = (state_q == S_SCAN);
	assign cmd.commit   = (state_q == S_COMMIT) && dp_status.out_free;
	assign cmd.found    = found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SCAN;
						found_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (dp_status.hit) begin
						found_q <= 1'b1;
						state_q <= S_COMMIT;
					end else if (dp_status.miss) begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					if (dp_status.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/ffba_datapath.sv =====
// Block table memory, scan pipeline, heap registers and result register.
`timescale 1ns / 1ps

module ffba_datapath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  ffba_pkg::ctrl_cmd_t                    cmd,
	output ffba_pkg::dp_status_t                   dp_status,
	input  logic                                   action,
	input  logic [ffba_pkg::SIZE_W-1:0]            request_size,
	input  logic [ffba_pkg::ADDR_W-1:0]            payload_address,
	input  logic                                   cfg_we,
	input  logic [ffba_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ffba_pkg::ADDR_W-1:0]            cfg_value,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [ffba_pkg::ADDR_W-1:0]            result_address,
	output logic [1:0]                             status,
	output logic                                   was_reused
);

	ffba_pkg::entry_t mem [ffba_pkg::MAX_BLOCKS];

	logic [ffba_pkg::ADDR_W-1:0] heap_limit_q;
	logic [ffba_pkg::ADDR_W-1:0] break_q;
	logic [ffba_pkg::CNT_W-1:0]  count_q;

	logic                        req_action_q;
	logic [ffba_pkg::SIZE_W-1:0] req_size_q;
	logic [ffba_pkg::ADDR_W-1:0] req_addr_q;

	logic [ffba_pkg::CNT_W-1:0]  scan_ptr_q;
	ffba_pkg::entry_t            rd_data_s1;
	logic [ffba_pkg::IDX_W-1:0]  chk_idx_s1;
	logic                        rd_valid_s1;

	logic                        out_valid_q;
	logic [ffba_pkg::ADDR_W-1:0] out_addr_q;
	ffba_pkg::status_t           out_status_q;
	logic                        out_reused_q;

	logic                        match;
	logic                        hit;
	logic                        issue;
	logic [ffba_pkg::ADDR_W+1:0] end_addr;
	logic                        oom;
	logic                        full;
	logic                        mem_we;
	logic [ffba_pkg::IDX_W-1:0]  mem_waddr;
	ffba_pkg::entry_t            mem_wdata;
	logic                        grow;

	always_comb begin
		if (req_action_q == ffba_pkg::ACT_ALLOC) begin
			match = rd_data_s1.free && (rd_data_s1.size >= req_size_q);
		end else begin
			match = ({1'b0, rd_data_s1.start} + {1'b0, ffba_pkg::HEADER_BYTES})
				== {1'b0, req_addr_q};
		end
	end

	assign hit   = cmd.scan_en && rd_valid_s1 && match;
	assign issue = cmd.scan_en && !hit && (scan_ptr_q < count_q);

	assign dp_status.hit      = hit;
	assign dp_status.miss     = cmd.scan_en && !rd_valid_s1 && (scan_ptr_q >= count_q);
	assign dp_status.out_free = !out_valid_q || !out_stall;

	assign end_addr = {2'b00, break_q} + {2'b00, ffba_pkg::HEADER_BYTES}
		+ {{(ffba_pkg::ADDR_W + 2 - ffba_pkg::SIZE_W){1'b0}}, req_size_q};
	assign oom  = end_addr > {2'b00, heap_limit_q};
	assign full = count_q == ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS);

	always_comb begin
		mem_we    = 1'b0;
		grow      = 1'b0;
		mem_waddr = chk_idx_s1;
		mem_wdata = rd_data_s1;
		if (cmd.commit) begin
			if (cmd.found) begin
				mem_we         = 1'b1;
				mem_wdata.free = (req_action_q == ffba_pkg::ACT_FREE);
			end else if (req_action_q == ffba_pkg::ACT_ALLOC && !oom && !full) begin
				mem_we          = 1'b1;
				grow            = 1'b1;
				mem_waddr       = count_q[ffba_pkg::IDX_W-1:0];
				mem_wdata.start = break_q;
				mem_wdata.size  = req_size_q;
				mem_wdata.free  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (issue) begin
			rd_data_s1 <= mem[scan_ptr_q[ffba_pkg::IDX_W-1:0]];
			chk_idx_s1 <= scan_ptr_q[ffba_pkg::IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_action_q <= action;
			req_size_q   <= request_size;
			req_addr_q   <= payload_address;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_ptr_q  <= '0;
			rd_valid_s1 <= 1'b0;
		end else if (cmd.load_req) begin
			scan_ptr_q  <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
			if (issue) begin
				scan_ptr_q <= scan_ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_limit_q <= '1;
			break_q      <= '0;
			count_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ffba_pkg::CFG_HEAP_START: begin
						if (count_q == '0) begin
							break_q <= cfg_value;
						end
					end
					ffba_pkg::CFG_HEAP_LIMIT: begin
						heap_limit_q <= cfg_value;
					end
					default: begin
					end
				endcase
			end
			if (grow) begin
				count_q <= count_q + 1'b1;
				break_q <= end_addr[ffba_pkg::ADDR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_addr_q   <= '0;
			out_status_q <= ffba_pkg::ST_OK;
			out_reused_q <= 1'b0;
			if (req_action_q == ffba_pkg::ACT_ALLOC) begin
				if (cmd.found) begin
					out_addr_q   <= rd_data_s1.start + ffba_pkg::HEADER_BYTES;
					out_reused_q <= 1'b1;
				end else if (oom) begin
					out_status_q <= ffba_pkg::ST_OOM;
				end else if (full) begin
					out_status_q <= ffba_pkg::ST_FULL;
				end else begin
					out_addr_q <= break_q + ffba_pkg::HEADER_BYTES;
				end
			end else if (!cmd.found) begin
				out_status_q <= ffba_pkg::ST_NOT_FOUND;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign result_address = out_addr_q;
	assign status         = out_status_q;
	assign was_reused     = out_reused_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS))
		else $error("block count beyond table depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		grow |=> count_q == $past(count_q) + 1'b1)
		else $error("block count did not advance on new block");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> {1'b0, chk_idx_s1} < count_q)
		else $error("scan read past last table entry");

	a_commit_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !out_valid_q || !out_stall)
		else $error("result overwritten while stalled");
`endif

endmodule

// ===== rtl/core/first_fit_block_allocator.sv =====
// First-fit heap block allocator: top level.
//
// Input channel (in_valid/in_stall) takes one request per transaction: action 0
// allocates request_size payload bytes, action 1 frees payload_address.
// Output channel (out_valid/out_stall) returns exactly one result per request:
// result_address, status (ok, out of memory, table full, not found), was_reused.
// The config channel (cfg_valid/cfg_ready, always ready) writes heap_start
// (index 0: moves the break, only while the table is empty) and heap_limit
// (index 1); other indexes are ignored. Write config only while idle.
// A request scans the block table in creation order, one entry per cycle
// through the single read port of the table memory. The scan stops at the
// first fit or match, else after all blocks of the table are read.
// One request is in flight at a time; the next one is taken at the edge after
// its predecessor enters the result register. While the receiver stalls,
// the result holds and a finished request waits in its commit step. Reset
// clears the table count, the break, the scan state and out_valid and sets
// heap_limit to all ones; table contents are not cleared, entries past the
// count are never read.
`timescale 1ns / 1ps

module first_fit_block_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           action,
	input  logic [ffba_pkg::SIZE_W-1:0]    request_size,
	input  logic [ffba_pkg::ADDR_W-1:0]    payload_address,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ffba_pkg::ADDR_W-1:0]    result_address,
	output logic [1:0]                     status,
	output logic                           was_reused,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ffba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ffba_pkg::ADDR_W-1:0]    cfg_value
);

	ffba_pkg::ctrl_cmd_t  cmd;
	ffba_pkg::dp_status_t dp_status;

	assign cfg_ready = 1'b1;

	ffba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.dp_status (dp_status),
		.cmd       (cmd)
	);

	ffba_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.dp_status       (dp_status),
		.action          (action),
		.request_size    (request_size),
		.payload_address (payload_address),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_value       (cfg_value),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.result_address  (result_address),
		.status          (status),
		.was_reused      (was_reused)
	);

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the first-fit block allocator: directed and random requests.
`timescale 1ns / 1ps

module testbench;

	localparam int CLK_HALF = 5;
	localparam int RESET_CYCLES = 10;
	localparam int RANDOM_PHASES = 25;
	localparam int PHASE_ITEMS = 50;
	localparam int HOLD_PHASE = 4;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT = 4000;
	localparam logic [ffba_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [ffba_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

	typedef struct {
		logic                        action;
		logic [ffba_pkg::SIZE_W-1:0] request_size;
		logic [ffba_pkg::ADDR_W-1:0] payload_address;
	} heap_req_t;

	typedef struct {
		logic [ffba_pkg::ADDR_W-1:0] result_address;
		ffba_pkg::status_t           status;
		logic                        was_reused;
	} heap_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = ffba_pkg::ACT_ALLOC;
	logic [ffba_pkg::SIZE_W-1:0] request_size = '0;
	logic [ffba_pkg::ADDR_W-1:0] payload_address = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [ffba_pkg::ADDR_W-1:0] result_address;
	logic [1:0] status;
	logic was_reused;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [ffba_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [ffba_pkg::ADDR_W-1:0] cfg_value = '0;

	first_fit_block_allocator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.request_size(request_size),
		.payload_address(payload_address),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_address(result_address),
		.status(status),
		.was_reused(was_reused),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_value(cfg_value)
	);

	always #CLK_HALF clk = ~clk;

	// allocator shadow state
	logic [ffba_pkg::ADDR_W-1:0] tbl_start [ffba_pkg::MAX_BLOCKS];
	logic [ffba_pkg::SIZE_W-1:0] tbl_size [ffba_pkg::MAX_BLOCKS];
	logic                        tbl_free [ffba_pkg::MAX_BLOCKS];
	int                          tbl_count = 0;
	logic [ffba_pkg::ADDR_W-1:0] brk = '0;
	logic [ffba_pkg::ADDR_W-1:0] cur_heap_start = '0;
	logic [ffba_pkg::ADDR_W-1:0] cur_heap_limit = '1;

	heap_req_t   request_backlog[$];
	heap_reply_t awaited_replies[$];
	int requests_queued = 0;
	int replies_seen = 0;
	int mismatches = 0;
	int idle_cycles = 0;
	int phase_no = 0;
	int max_gap = 5;
	int max_stall = 5;
	int gap_left = 0;
	int rx_wait = 0;
	bit long_hold_done = 1'b0;
	bit in_fire = 1'b0;
	bit out_fire = 1'b0;

	function automatic heap_reply_t service_request(heap_req_t r);
		heap_reply_t rep;
		logic [ffba_pkg::ADDR_W:0] block_end;
		bit done;
		rep.result_address = '0;
		rep.status = ffba_pkg::ST_OK;
		rep.was_reused = 1'b0;
		done = 1'b0;
		if (r.action == ffba_pkg::ACT_ALLOC) begin
			for (int k = 0; k < tbl_count; k++) begin
				if (!done && tbl_free[k] && tbl_size[k] >= r.request_size) begin
					tbl_free[k] = 1'b0;
					rep.result_address = tbl_start[k] + ffba_pkg::HEADER_BYTES;
					rep.was_reused = 1'b1;
					done = 1'b1;
				end
			end
			if (!done) begin
				block_end = {1'b0, brk} + {1'b0, ffba_pkg::HEADER_BYTES}
					+ (ffba_pkg::ADDR_W + 1)'(r.request_size);
				if (block_end > {1'b0, cur_heap_limit}) begin
					rep.status = ffba_pkg::ST_OOM;
				end else if (tbl_count == ffba_pkg::MAX_BLOCKS) begin
					rep.status = ffba_pkg::ST_FULL;
				end else begin
					tbl_start[tbl_count] = brk;
					tbl_size[tbl_count] = r.request_size;
					tbl_free[tbl_count] = 1'b0;
					tbl_count++;
					rep.result_address = brk + ffba_pkg::HEADER_BYTES;
					brk = block_end[ffba_pkg::ADDR_W-1:0];
				end
			end
		end else begin
			for (int k = 0; k < tbl_count; k++) begin
				if (!done && {1'b0, tbl_start[k]} + {1'b0, ffba_pkg::HEADER_BYTES}
						== {1'b0, r.payload_address}) begin
					tbl_free[k] = 1'b1;
					done = 1'b1;
				end
			end
			if (!done)
				rep.status = ffba_pkg::ST_NOT_FOUND;
		end
		return rep;
	endfunction

	task automatic report_mismatch(string what, logic [ffba_pkg::ADDR_W-1:0] got,
			logic [ffba_pkg::ADDR_W-1:0] want);
		mismatches++;
		$display("mismatch %s: got %h expected %h (reply %0d, t=%0t)", what, got, want,
			replies_seen, $realtime);
	endtask

	// sample both channels and the config port; predict, compare, watchdog
	always @(posedge clk) begin
		heap_req_t   req;
		heap_reply_t want;
		in_fire = arst_n && in_valid && !in_stall;
		out_fire = arst_n && out_valid && !out_stall;
		if (out_fire) begin
			replies_seen++;
			if (awaited_replies.size() == 0) begin
				report_mismatch("unexpected reply", result_address, '0);
			end else begin
				want = awaited_replies.pop_front();
				if (result_address !== want.result_address)
					report_mismatch("result_address", result_address, want.result_address);
				if (status !== want.status)
					report_mismatch("status", ffba_pkg::ADDR_W'(status),
						ffba_pkg::ADDR_W'(want.status));
				if (was_reused !== want.was_reused)
					report_mismatch("was_reused", ffba_pkg::ADDR_W'(was_reused),
						ffba_pkg::ADDR_W'(want.was_reused));
			end
		end
		if (in_fire) begin
			req.action = action;
			req.request_size = request_size;
			req.payload_address = payload_address;
			awaited_replies.push_back(service_request(req));
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				ffba_pkg::CFG_HEAP_START: begin
					cur_heap_start = cfg_value;
					if (tbl_count == 0)
						brk = cfg_value;
				end
				ffba_pkg::CFG_HEAP_LIMIT: cur_heap_limit = cfg_value;
				default: ;
			endcase
		end
		if (arst_n) begin
			if (in_fire || out_fire || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout after %0d idle cycles", idle_cycles);
				$display("FAIL");
				$finish;
			end
		end
	end

	// request driver
	always @(negedge clk) begin
		heap_req_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_fire) begin
			// stalled transaction holds
		end else if (gap_left != 0) begin
			gap_left <= gap_left - 1;
			in_valid <= 1'b0;
		end else if (request_backlog.size() != 0) begin
			r = request_backlog.pop_front();
			action <= r.action;
			request_size <= r.request_size;
			payload_address <= r.payload_address;
			in_valid <= 1'b1;
			gap_left <= $urandom_range(0, max_gap);
		end else begin
			in_valid <= 1'b0;
		end
	end

	// reply receiver stall
	always @(negedge clk) begin
		int w;
		w = rx_wait;
		if (out_fire)
			w = $urandom_range(0, max_stall);
		if (phase_no == HOLD_PHASE && out_valid && !long_hold_done) begin
			w = HOLD_CYCLES;
			long_hold_done = 1'b1;
		end
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_wait <= 0;
		end else if (w != 0) begin
			out_stall <= 1'b1;
			rx_wait <= w - 1;
		end else begin
			out_stall <= 1'b0;
			rx_wait <= 0;
		end
	end

	task automatic cfg_write(logic [ffba_pkg::CFG_IDX_W-1:0] idx,
			logic [ffba_pkg::ADDR_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_value <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic push_request(logic act, logic [ffba_pkg::SIZE_W-1:0] sz,
			logic [ffba_pkg::ADDR_W-1:0] addr);
		heap_req_t r;
		r.action = act;
		r.request_size = sz;
		r.payload_address = addr;
		request_backlog.push_back(r);
		requests_queued++;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (replies_seen != requests_queued);
		repeat (4) @(negedge clk);
	endtask

	task automatic push_random_request();
		logic [ffba_pkg::SIZE_W-1:0] sz;
		logic [ffba_pkg::ADDR_W-1:0] addr;
		int pick;
		sz = ffba_pkg::SIZE_W'($urandom());
		addr = $urandom();
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < 55) begin
			if (pick < 65)
				sz = ffba_pkg::SIZE_W'($urandom_range(0, 64));
			else if (pick < 85)
				sz = ffba_pkg::SIZE_W'($urandom_range(0, 4095));
			else if (pick >= 95)
				sz = '1;
			push_request(ffba_pkg::ACT_ALLOC, sz, addr);
		end else begin
			if (tbl_count != 0 && pick < 75)
				addr = tbl_start[$urandom_range(0, tbl_count - 1)] + ffba_pkg::HEADER_BYTES;
			else if (tbl_count != 0 && pick < 88)
				addr = tbl_start[$urandom_range(0, tbl_count - 1)] + ffba_pkg::HEADER_BYTES
					+ ($urandom_range(0, 1) ? 32'd1 : -32'd1);
			push_request(ffba_pkg::ACT_FREE, sz, addr);
		end
	endtask

	task automatic pick_phase_config();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: cfg_write(ffba_pkg::CFG_HEAP_LIMIT, '1);
			4, 5: cfg_write(ffba_pkg::CFG_HEAP_LIMIT, brk + $urandom_range(0, 400));
			6: cfg_write(ffba_pkg::CFG_HEAP_LIMIT,
				$urandom_range(0, 1) ? '0 : $urandom_range(0, brk));
			7: cfg_write(ffba_pkg::CFG_HEAP_START, $urandom());
			8: cfg_write(CFG_SPARE_2, $urandom());
			default: cfg_write(CFG_SPARE_3, $urandom());
		endcase
	endtask

	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// break at the top of the address space: no wrap past it
		cfg_write(ffba_pkg::CFG_HEAP_START, '1);
		push_request(ffba_pkg::ACT_ALLOC, '0, '1);
		push_request(ffba_pkg::ACT_FREE, '1, '0);
		push_request(ffba_pkg::ACT_FREE, '0, '1);
		wait_drained();

		cfg_write(ffba_pkg::CFG_HEAP_START, '0);
		cfg_write(ffba_pkg::CFG_HEAP_LIMIT, '0);
		push_request(ffba_pkg::ACT_ALLOC, '0, '0);
		wait_drained();

		// exact fit of a header-only block, then one byte too many
		cfg_write(ffba_pkg::CFG_HEAP_LIMIT, ffba_pkg::HEADER_BYTES);
		push_request(ffba_pkg::ACT_ALLOC, '0, '0);
		push_request(ffba_pkg::ACT_ALLOC, 24'd1, '0);
		wait_drained();

		cfg_write(ffba_pkg::CFG_HEAP_LIMIT, '1);
		cfg_write(CFG_SPARE_2, $urandom());
		cfg_write(CFG_SPARE_3, $urandom());
		cfg_write(ffba_pkg::CFG_HEAP_START, 32'h0001_0000);
		push_request(ffba_pkg::ACT_ALLOC, '1, '0);
		push_request(ffba_pkg::ACT_ALLOC, 24'd100, '0);
		push_request(ffba_pkg::ACT_FREE, '0, 2 * ffba_pkg::HEADER_BYTES);
		push_request(ffba_pkg::ACT_FREE, '0, 2 * ffba_pkg::HEADER_BYTES);
		push_request(ffba_pkg::ACT_ALLOC, 24'd200, '0);
		push_request(ffba_pkg::ACT_FREE, '0, ffba_pkg::HEADER_BYTES);
		push_request(ffba_pkg::ACT_ALLOC, '0, '0);
		push_request(ffba_pkg::ACT_FREE, '0, ffba_pkg::HEADER_BYTES + 1);
		push_request(ffba_pkg::ACT_ALLOC, '0, '0);
		push_request(ffba_pkg::ACT_ALLOC, '1, '0);
		wait_drained();

		for (int ph = 1; ph <= RANDOM_PHASES; ph++) begin
			phase_no <= ph;
			max_gap <= (ph % 4 == 2) ? 0 : 5;
			max_stall <= (ph % 4 == 3) ? 0 : 5;
			pick_phase_config();
			for (int n = 0; n < PHASE_ITEMS; n++)
				push_random_request();
			wait_drained();
		end

		if (awaited_replies.size() != 0)
			report_mismatch("missing replies", '0,
				ffba_pkg::ADDR_W'(awaited_replies.size()));
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== first_fit_block_allocator.f =====
rtl/core/ffba_pkg.sv
rtl/core/ffba_ctrl.sv
rtl/core/ffba_datapath.sv
rtl/core/first_fit_block_allocator.sv
tb/testbench.sv
